@@ hdl/abfs_pkg.sv @@
// abfs_pkg: shared types, constants and helper functions of the alert
// beep and flash sequencer
// no dependencies
`default_nettype none

package abfs_pkg;

  // alert queue sizing
  localparam int QUEUE_DEPTH = 3;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // flash phase divider width, one quotient bit per step
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // intensity codes
  localparam logic [3:0] CODE_INVALID   = 4'd0;
  localparam logic [3:0] CODE_DOUBLE_LO = 4'd3;
  localparam logic [3:0] CODE_DOUBLE_HI = 4'd4;
  localparam logic [3:0] CODE_TRIPLE_LO = 4'd5;
  localparam logic [3:0] CODE_TRIPLE_HI = 4'd9;

  // register reset values and background color
  localparam logic [15:0] BEEP_PERIOD_RST    = 16'd250;
  localparam logic [15:0] FLASH_DURATION_RST = 16'd1500;
  localparam logic [15:0] FLASH_INTERVAL_RST = 16'd300;
  localparam logic [15:0] COLOR_BACKGROUND   = 16'h0000;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SPEAKER_ENABLE = 2'd0,
    REG_BEEP_PERIOD    = 2'd1,
    REG_FLASH_DURATION = 2'd2,
    REG_FLASH_INTERVAL = 2'd3
  } abfs_reg_t;

  // fill modes
  typedef enum logic [1:0] {
    FILL_NONE       = 2'd0,
    FILL_COLOR      = 2'd1,
    FILL_BACKGROUND = 2'd2,
    FILL_REDRAW     = 2'd3
  } abfs_fill_t;

  typedef struct packed {
    logic        speaker_enable;
    logic [15:0] beep_period;
    logic [15:0] flash_duration;
    logic [15:0] flash_interval;
  } abfs_cfg_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] color;
    logic [15:0] tag;
  } abfs_entry_t;

  // one result word
  typedef struct packed {
    logic        tone_start;
    abfs_fill_t  fill_mode;
    logic [15:0] fill_color;
    logic        alert_started;
    logic [15:0] started_tag;
    logic        dropped_oldest;
    logic        rejected;
    logic [1:0]  pending_count;
  } abfs_result_t;

  function automatic logic [1:0] beeps_for_code(input logic [3:0] code);
    logic [1:0] n;
    if (code >= CODE_TRIPLE_LO && code <= CODE_TRIPLE_HI) begin
      n = 2'd3;
    end else if (code == CODE_DOUBLE_LO || code == CODE_DOUBLE_HI) begin
      n = 2'd2;
    end else begin
      n = 2'd1;
    end
    return n;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] idx);
    return (idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + QIDX_W'(1);
  endfunction

  function automatic logic [1:0] sat_pending(input logic [QCNT_W-1:0] cnt);
    return (int'(cnt) > 3) ? 2'd3 : 2'(cnt);
  endfunction

endpackage

`default_nettype wire

@@ hdl/abfs_if.sv @@
// abfs_alert_if, abfs_result_if: valid/ready channels of the sequencer
// no dependencies
`default_nettype none

interface abfs_alert_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        touch_pressed;
  logic [3:0]  intensity_code;
  logic [15:0] alert_color;
  logic [15:0] alert_tag;

  modport source (
    output valid, action, touch_pressed, intensity_code, alert_color, alert_tag,
    input  ready
  );
  modport sink (
    input  valid, action, touch_pressed, intensity_code, alert_color, alert_tag,
    output ready
  );
endinterface

interface abfs_result_if;
  logic        valid;
  logic        ready;
  logic        tone_start;
  logic [1:0]  fill_mode;
  logic [15:0] fill_color;
  logic        alert_started;
  logic [15:0] started_tag;
  logic        dropped_oldest;
  logic        rejected;
  logic [1:0]  pending_count;

  modport source (
    output valid, tone_start, fill_mode, fill_color, alert_started, started_tag,
           dropped_oldest, rejected, pending_count,
    input  ready
  );
  modport sink (
    input  valid, tone_start, fill_mode, fill_color, alert_started, started_tag,
           dropped_oldest, rejected, pending_count,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/abfs_core.sv @@
// abfs_core: alert queue, beep sequencer and flash timer state, updated
// once per accepted word, with the result word built in the same pass
// depends on abfs_pkg
`default_nettype none

module abfs_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                action,
  input  wire logic                touch_pressed,
  input  wire logic [3:0]          intensity_code,
  input  wire logic [15:0]         alert_color,
  input  wire logic [15:0]         alert_tag,
  input  wire abfs_pkg::abfs_cfg_t cfg,
  input  wire logic                phase_load,
  input  wire logic [15:0]         phase_rem,
  input  wire logic                phase_odd,
  output abfs_pkg::abfs_result_t   res,
  output logic [15:0]              flash_time
);

  // alert store, contents undefined until written
  abfs_pkg::abfs_entry_t alert_store [abfs_pkg::QUEUE_DEPTH];

  logic [abfs_pkg::QIDX_W-1:0] head_index, head_index_next;
  logic [abfs_pkg::QIDX_W-1:0] tail_index, tail_index_next;
  logic [abfs_pkg::QCNT_W-1:0] waiting_count, waiting_count_next;
  logic [1:0]                  beeps_total, beeps_total_next;
  logic [1:0]                  beeps_done, beeps_done_next;
  logic [15:0]                 beep_timer, beep_timer_next;
  logic                        flash_active, flash_active_next;
  logic [15:0]                 flash_timer, flash_timer_next;
  logic [15:0]                 flash_phase_timer, flash_phase_timer_next;
  logic                        flash_odd, flash_odd_next;
  logic [15:0]                 flash_color_reg, flash_color_reg_next;

  logic [abfs_pkg::QIDX_W-1:0] head_drop;
  logic [abfs_pkg::QCNT_W-1:0] count_drop;
  logic                        start_ok;
  logic [15:0]                 beep_sat;
  logic [1:0]                  done_inc;
  logic [15:0]                 phase_inc;
  logic [15:0]                 flash_ivl;
  logic                        store_we;
  abfs_pkg::abfs_entry_t       new_entry;
  abfs_pkg::abfs_entry_t       start_entry;

  assign new_entry = '{code: intensity_code, color: alert_color, tag: alert_tag};
  assign store_we  = accept && action && (intensity_code != abfs_pkg::CODE_INVALID);
  assign flash_ivl = (cfg.flash_interval == '0) ? 16'd1 : cfg.flash_interval;

  // next state and result word
  always_comb begin
    head_index_next        = head_index;
    tail_index_next        = tail_index;
    waiting_count_next     = waiting_count;
    beeps_total_next       = beeps_total;
    beeps_done_next        = beeps_done;
    beep_timer_next        = beep_timer;
    flash_active_next      = flash_active;
    flash_timer_next       = flash_timer;
    flash_phase_timer_next = flash_phase_timer;
    flash_odd_next         = flash_odd;
    flash_color_reg_next   = flash_color_reg;
    head_drop              = head_index;
    count_drop             = waiting_count;
    start_ok               = 1'b0;
    beep_sat               = beep_timer;
    done_inc               = beeps_done;
    phase_inc              = flash_phase_timer;
    res                    = '0;
    res.fill_mode          = abfs_pkg::FILL_NONE;
    res.fill_color         = abfs_pkg::COLOR_BACKGROUND;

    if (action) begin
      // new alert: reject, drop oldest if full, then enqueue
      if (intensity_code == abfs_pkg::CODE_INVALID) begin
        res.rejected = 1'b1;
      end else begin
        if (waiting_count == abfs_pkg::QCNT_W'(abfs_pkg::QUEUE_DEPTH)) begin
          head_drop          = abfs_pkg::idx_inc(head_index);
          count_drop         = waiting_count - abfs_pkg::QCNT_W'(1);
          res.dropped_oldest = 1'b1;
        end
        head_index_next    = head_drop;
        tail_index_next    = abfs_pkg::idx_inc(tail_index);
        waiting_count_next = count_drop + abfs_pkg::QCNT_W'(1);
        start_ok           = (beeps_total == 2'd0);
      end
    end else begin
      // tick: advance flash time and its phase within the interval
      if (flash_active) begin
        flash_timer_next = abfs_pkg::sat_inc16(flash_timer);
        if (flash_timer != 16'hFFFF) begin
          phase_inc = flash_phase_timer + 16'd1;
          if (phase_inc >= flash_ivl) begin
            flash_phase_timer_next = '0;
            flash_odd_next         = !flash_odd;
          end else begin
            flash_phase_timer_next = phase_inc;
          end
        end
      end
      // beep sequence
      if (beeps_done < beeps_total) begin
        beep_sat        = abfs_pkg::sat_inc16(beep_timer);
        beep_timer_next = beep_sat;
        if (beep_sat >= cfg.beep_period) begin
          done_inc = beeps_done + 2'd1;
          if (done_inc < beeps_total) begin
            res.tone_start  = cfg.speaker_enable;
            beep_timer_next = '0;
            beeps_done_next = done_inc;
          end else begin
            beeps_total_next = '0;
            beeps_done_next  = '0;
            start_ok         = (waiting_count != '0);
          end
        end
      end
    end

    // head alert, bypassed from the incoming word when the queue was empty
    if (action && count_drop == '0) begin
      start_entry = new_entry;
    end else begin
      start_entry = alert_store[head_drop];
    end

    // start the head alert
    if (start_ok) begin
      head_index_next        = abfs_pkg::idx_inc(head_drop);
      waiting_count_next     = waiting_count_next - abfs_pkg::QCNT_W'(1);
      beeps_total_next       = abfs_pkg::beeps_for_code(start_entry.code);
      beeps_done_next        = '0;
      beep_timer_next        = '0;
      res.tone_start         = cfg.speaker_enable;
      flash_active_next      = 1'b1;
      flash_timer_next       = '0;
      flash_phase_timer_next = '0;
      flash_odd_next         = 1'b0;
      flash_color_reg_next   = start_entry.color;
      res.alert_started      = 1'b1;
      res.started_tag        = start_entry.tag;
    end

    // flash update on ticks
    if (!action && flash_active_next) begin
      if (touch_pressed || flash_timer_next >= cfg.flash_duration) begin
        flash_active_next = 1'b0;
        res.fill_mode     = abfs_pkg::FILL_REDRAW;
      end else if (flash_odd_next) begin
        res.fill_mode = abfs_pkg::FILL_BACKGROUND;
      end else begin
        res.fill_mode  = abfs_pkg::FILL_COLOR;
        res.fill_color = flash_color_reg_next;
      end
    end

    res.pending_count = abfs_pkg::sat_pending(waiting_count_next);
  end

  assign flash_time = flash_timer;

  // control state; the phase reloads after an interval change
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index        <= '0;
      tail_index        <= '0;
      waiting_count     <= '0;
      beeps_total       <= '0;
      beeps_done        <= '0;
      beep_timer        <= '0;
      flash_active      <= 1'b0;
      flash_timer       <= '0;
      flash_phase_timer <= '0;
      flash_odd         <= 1'b0;
      flash_color_reg   <= '0;
    end else if (accept) begin
      head_index        <= head_index_next;
      tail_index        <= tail_index_next;
      waiting_count     <= waiting_count_next;
      beeps_total       <= beeps_total_next;
      beeps_done        <= beeps_done_next;
      beep_timer        <= beep_timer_next;
      flash_active      <= flash_active_next;
      flash_timer       <= flash_timer_next;
      flash_phase_timer <= flash_phase_timer_next;
      flash_odd         <= flash_odd_next;
      flash_color_reg   <= flash_color_reg_next;
    end else if (phase_load) begin
      flash_phase_timer <= phase_rem;
      flash_odd         <= phase_odd;
    end
  end

  // alert store write at the tail
  always_ff @(posedge clk) begin
    if (store_we) begin
      alert_store[tail_index] <= new_entry;
    end
  end

endmodule

`default_nettype wire

@@ hdl/abfs_div.sv @@
// abfs_div: iterative restoring divider that finds the remainder and the
// quotient parity of flash_time / interval, one quotient bit per cycle
// depends on abfs_pkg
`default_nettype none

module abfs_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [15:0]      rem,
  output logic             quot_odd
);

  logic [abfs_pkg::DIV_W-1:0]     num;
  logic [abfs_pkg::DIV_W-1:0]     den;
  logic [abfs_pkg::DIV_CNT_W-1:0] steps;
  logic [abfs_pkg::DIV_W:0]       shifted;
  logic                           ge;

  // one shift and subtract step
  assign shifted = {rem, num[abfs_pkg::DIV_W-1]};
  assign ge      = (shifted >= {1'b0, den});
  assign busy    = (steps != '0);

  // step counter, done pulses once after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= abfs_pkg::DIV_CNT_W'(abfs_pkg::DIV_W);
      done  <= 1'b0;
    end else begin
      if (busy) begin
        steps <= steps - abfs_pkg::DIV_CNT_W'(1);
      end
      done <= (steps == abfs_pkg::DIV_CNT_W'(1));
    end
  end

  // partial remainder, shifting dividend and latest quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      num      <= dividend;
      den      <= divisor;
      quot_odd <= 1'b0;
    end else if (busy) begin
      rem      <= ge ? abfs_pkg::DIV_W'(shifted - {1'b0, den})
                     : shifted[abfs_pkg::DIV_W-1:0];
      num      <= {num[abfs_pkg::DIV_W-2:0], 1'b0};
      quot_odd <= ge;
    end
  end

endmodule

`default_nettype wire

@@ hdl/alert_beep_flash_sequencer.sv @@
// alert_beep_flash_sequencer: top level with configuration registers,
// state update core, result register and flash phase divider
// depends on abfs_pkg, abfs_if, abfs_core, abfs_div
//
//   channel     dir  handshake      contents
//   alert_in    in   valid/ready    action, touch, intensity, color, tag
//   result_out  out  valid/ready    tone, fill mode and color, start, status
//   cfg         in   cfg_we         cfg_index selects, cfg_data written
//
// One word is accepted per cycle while alert_in.ready is high; the core
// updates its state in that cycle, the result register shows it next cycle.
// A stalled result_out holds the result register and drops alert_in.ready.
// A write to the flash interval register reloads the flash phase with a
// 16-step divider; alert_in.ready stays low until the new phase is loaded.
// Reset empties the queue, stops beeps and flash and loads the defaults.
`default_nettype none

module alert_beep_flash_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  abfs_alert_if.sink       alert_in,
  abfs_result_if.source    result_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  abfs_pkg::abfs_cfg_t    cfg;
  abfs_pkg::abfs_result_t core_res;
  abfs_pkg::abfs_result_t res;
  logic                   res_valid;
  logic [15:0]            flash_time;
  logic                   accept;
  logic                   ivl_write;
  logic [15:0]            ivl_new;
  logic                   div_busy;
  logic                   div_done;
  logic [15:0]            div_rem;
  logic                   div_odd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speaker_enable <= 1'b0;
      cfg.beep_period    <= abfs_pkg::BEEP_PERIOD_RST;
      cfg.flash_duration <= abfs_pkg::FLASH_DURATION_RST;
      cfg.flash_interval <= abfs_pkg::FLASH_INTERVAL_RST;
    end else if (cfg_we) begin
      case (abfs_pkg::abfs_reg_t'(cfg_index))
        abfs_pkg::REG_SPEAKER_ENABLE: cfg.speaker_enable <= cfg_data[0];
        abfs_pkg::REG_BEEP_PERIOD:    cfg.beep_period    <= cfg_data;
        abfs_pkg::REG_FLASH_DURATION: cfg.flash_duration <= cfg_data;
        abfs_pkg::REG_FLASH_INTERVAL: cfg.flash_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // interval writes restart the phase divider, zero acts as one
  assign ivl_write = cfg_we &&
                     (abfs_pkg::abfs_reg_t'(cfg_index) == abfs_pkg::REG_FLASH_INTERVAL);
  assign ivl_new   = (cfg_data == '0) ? 16'd1 : cfg_data;

  // input waits for a free result register and a settled phase
  assign alert_in.ready = !div_busy && !div_done && (!res_valid || result_out.ready);
  assign accept         = alert_in.valid && alert_in.ready;

  abfs_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .action         (alert_in.action),
    .touch_pressed  (alert_in.touch_pressed),
    .intensity_code (alert_in.intensity_code),
    .alert_color    (alert_in.alert_color),
    .alert_tag      (alert_in.alert_tag),
    .cfg            (cfg),
    .phase_load     (div_done),
    .phase_rem      (div_rem),
    .phase_odd      (div_odd),
    .res            (core_res),
    .flash_time     (flash_time)
  );

  abfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ivl_write),
    .dividend (flash_time),
    .divisor  (ivl_new),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem),
    .quot_odd (div_odd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= core_res;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.tone_start     = res.tone_start;
  assign result_out.fill_mode      = res.fill_mode;
  assign result_out.fill_color     = res.fill_color;
  assign result_out.alert_started  = res.alert_started;
  assign result_out.started_tag    = res.started_tag;
  assign result_out.dropped_oldest = res.dropped_oldest;
  assign result_out.rejected       = res.rejected;
  assign result_out.pending_count  = res.pending_count;

endmodule

`default_nettype wire
